FILE: rtl/tw_pkg.sv
`timescale 1ns / 1ps
// Shared widths, character codes and types for the temperature text block.
// Depends on nothing; every other file takes names from here by scope.
package tw_pkg;

   localparam int RAW_W  = 12;   // signed sensor word
   localparam int MAG_W  = 12;   // magnitude, up to 2048
   localparam int HUND_W = 14;   // hundredths of a degree, up to 12800
   localparam int CHAR_W = 8;
   localparam int DIG_W  = 4;

   localparam int FIFO_DEPTH = 2;

   localparam logic [HUND_W-1:0] HUND_MAX  = HUND_W'(12800);
   localparam logic [HUND_W-1:0] TEN_THOUS = HUND_W'(10000);

   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

   // One classified value waiting for the text sequencer.
   typedef struct packed {
      logic              neg;    // negative and nonzero
      logic [HUND_W-1:0] hund;   // magnitude in hundredths
   } tw_entry_type;

   typedef struct packed {
      logic [DIG_W-1:0]  digit;
      logic [HUND_W-1:0] rest;
   } tw_digit_type;

   // One decimal digit of a value known to lie below ten times place.
   // Nine independent compares against constant multiples, then select.
   function automatic tw_digit_type tw_digit(input logic [HUND_W-1:0] value,
                                             input int unsigned place);
      tw_digit_type res;
      res.digit = '0;
      res.rest  = value;
      for (int unsigned k = 1; k <= 9; k++) begin
         if (value >= HUND_W'(k * place)) begin
            res.digit = DIG_W'(k);
            res.rest  = value - HUND_W'(k * place);
         end
      end
      return res;
   endfunction

   function automatic logic [CHAR_W-1:0] tw_digit_char(input logic [DIG_W-1:0] d);
      return CHAR_ZERO + {{(CHAR_W-DIG_W){1'b0}}, d};
   endfunction

endpackage

FILE: rtl/tw_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sensor word and the text characters.
// Depends on tw_pkg for field widths.
interface tw_req_if;
   logic                             valid;
   logic                             ready;
   logic signed [tw_pkg::RAW_W-1:0]  raw_temp;

   modport source (output valid, output raw_temp, input ready);
   modport sink   (input valid, input raw_temp, output ready);
endinterface

interface tw_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [tw_pkg::CHAR_W-1:0]   char_code;
   logic                        last_char;

   modport source (output valid, output char_code, output last_char, input ready);
   modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

FILE: rtl/tw_front.sv
`timescale 1ns / 1ps
// Front stage: accept a sensor word, take its magnitude and round to hundredths.
// Depends on tw_pkg and tw_req_if.
module tw_front (
   input  logic                 clock,
   input  logic                 reset,
   tw_req_if.sink               req_if,
   output logic                 push_valid,
   input  logic                 push_ready,
   output tw_pkg::tw_entry_type push_entry
);

   logic                        valid_ff, valid_in;
   tw_pkg::tw_entry_type        entry_ff, entry_in;
   logic [tw_pkg::RAW_W-1:0]    raw_bits;
   logic                        neg;
   logic [tw_pkg::MAG_W-1:0]    mag;
   logic [15:0]                 scaled;
   logic                        take;

   assign raw_bits = req_if.raw_temp;
   assign neg      = raw_bits[tw_pkg::RAW_W-1];
   assign mag      = neg ? (~raw_bits + 1'b1) : raw_bits;

   // (mag*625 + 50) / 100 equals (mag*25 + 2) / 4
   assign scaled = {mag, 4'b0000} + {1'b0, mag, 3'b000} + {4'b0000, mag} + 16'd2;

   always_comb begin
      entry_in.hund = scaled[tw_pkg::HUND_W+1:2];
      entry_in.neg  = neg && (entry_in.hund != '0);
   end

   assign req_if.ready = !valid_ff || push_ready;
   assign take         = req_if.valid && req_if.ready;
   assign valid_in     = take || (valid_ff && !push_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (take) begin
         entry_ff <= entry_in;
      end
   end

   assign push_valid = valid_ff;
   assign push_entry = entry_ff;

endmodule

FILE: rtl/tw_fifo.sv
`timescale 1ns / 1ps
// Short register queue between the front stage and the text sequencer.
// Depends on tw_pkg for the entry type.
module tw_fifo #(
   parameter int Depth = tw_pkg::FIFO_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  tw_pkg::tw_entry_type push_entry,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output tw_pkg::tw_entry_type pop_entry
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   tw_pkg::tw_entry_type slots_ff [Depth];
   logic [PtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]      count_ff, count_in;
   logic                 push, pop;

   assign push_ready = (count_ff != CntW'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slots_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: rtl/tw_back.sv
`timescale 1ns / 1ps
// Text sequencer: walk one value's characters out, one per cycle while the
// receiver is ready, into an output register. Depends on tw_pkg and tw_rsp_if.
module tw_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   output logic                 head_pop,
   input  tw_pkg::tw_entry_type head_entry,
   tw_rsp_if.source             rsp_if
);

   typedef enum logic [2:0] {
      PH_SIGN,
      PH_TTH,
      PH_TH,
      PH_HUN,
      PH_DOT,
      PH_TEN,
      PH_UNIT
   } phase_type;

   phase_type                   phase_ff, phase_in;
   logic                        busy_ff;
   logic                        neg_ff;
   logic [tw_pkg::HUND_W-1:0]   rem_ff, rem_in;
   logic                        rsp_valid_ff;
   logic [tw_pkg::CHAR_W-1:0]   char_ff, char_in;
   logic                        last_ff, last_in;
   logic                        take_out, advance, load, finish;
   tw_pkg::tw_digit_type        d_th, d_hun, d_ten;

   assign d_th  = tw_pkg::tw_digit(rem_ff, 1000);
   assign d_hun = tw_pkg::tw_digit(rem_ff, 100);
   assign d_ten = tw_pkg::tw_digit(rem_ff, 10);

   assign take_out = !rsp_valid_ff || rsp_if.ready;
   assign advance  = busy_ff && take_out;
   assign finish   = advance && (phase_ff == PH_UNIT);
   assign load     = head_valid && (!busy_ff || finish);
   assign head_pop = load;

   always_comb begin
      phase_in = phase_ff;
      rem_in   = rem_ff;
      char_in  = tw_pkg::CHAR_ZERO;
      last_in  = 1'b0;
      unique case (phase_ff)
         PH_SIGN: begin
            char_in  = neg_ff ? tw_pkg::CHAR_MINUS : tw_pkg::CHAR_PLUS;
            phase_in = (rem_ff >= tw_pkg::TEN_THOUS) ? PH_TTH : PH_TH;
         end
         PH_TTH: begin
            // magnitude never reaches 20000, so this digit is one
            char_in  = tw_pkg::tw_digit_char(4'd1);
            rem_in   = rem_ff - tw_pkg::TEN_THOUS;
            phase_in = PH_TH;
         end
         PH_TH: begin
            char_in  = tw_pkg::tw_digit_char(d_th.digit);
            rem_in   = d_th.rest;
            phase_in = PH_HUN;
         end
         PH_HUN: begin
            char_in  = tw_pkg::tw_digit_char(d_hun.digit);
            rem_in   = d_hun.rest;
            phase_in = PH_DOT;
         end
         PH_DOT: begin
            char_in  = tw_pkg::CHAR_DOT;
            phase_in = PH_TEN;
         end
         PH_TEN: begin
            char_in  = tw_pkg::tw_digit_char(d_ten.digit);
            rem_in   = d_ten.rest;
            phase_in = PH_UNIT;
         end
         PH_UNIT: begin
            char_in  = tw_pkg::tw_digit_char(rem_ff[tw_pkg::DIG_W-1:0]);
            last_in  = 1'b1;
            phase_in = PH_SIGN;
         end
         default: begin
            phase_in = PH_SIGN;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff     <= PH_SIGN;
      end else begin
         if (take_out) begin
            rsp_valid_ff <= advance;
         end
         if (advance) begin
            char_ff <= char_in;
            last_ff <= last_in;
         end
         // A new value takes over the walk state, even on its predecessor's last character.
         if (load) begin
            busy_ff  <= 1'b1;
            phase_ff <= PH_SIGN;
            rem_ff   <= head_entry.hund;
            neg_ff   <= head_entry.neg;
         end else if (advance) begin
            rem_ff   <= rem_in;
            phase_ff <= phase_in;
            if (finish) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign rsp_if.valid     = rsp_valid_ff;
   assign rsp_if.char_code = char_ff;
   assign rsp_if.last_char = last_ff;

endmodule

FILE: rtl/temperature_word_to_ascii.sv
`timescale 1ns / 1ps
// The sign, first character out, passes the front register, queue and walk state into
// the output register. Throughput, set by the text sequencer: one character per cycle
// while the receiver is ready; six characters a word, seven at 100.00 degrees or more.
// A new word is taken while the previous one is still being spelled out.
// Reset (synchronous, active high) empties the front stage, queue and output register.
module temperature_word_to_ascii #(
   parameter int FifoDepth = tw_pkg::FIFO_DEPTH
) (
   input  logic      clock,
   input  logic      reset,
   tw_req_if.sink    req_if,
   tw_rsp_if.source  rsp_if
);

   // Front stage to queue
   logic                 front_valid;
   logic                 front_ready;
   tw_pkg::tw_entry_type front_entry;

   // Queue to sequencer
   logic                 head_valid;
   logic                 head_pop;
   tw_pkg::tw_entry_type head_entry;

   // Accept a word, rectify it and round to hundredths in one registered step.
   tw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_entry (front_entry)
   );

   // Decouple the rounding stage from the character sequencer, so a new
   // word can be taken while the back end is still busy.
   tw_fifo #(
      .Depth (FifoDepth)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_entry (front_entry),
      .pop_valid  (head_valid),
      .pop_ready  (head_pop),
      .pop_entry  (head_entry)
   );

   // Spell the value out: sign, optional hundreds-of-degrees digit, two
   // integer digits, point, two fractional digits. The two integer digits and
   // the tenths digit come from a bank of constant compares on the running remainder.
   tw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head_entry (head_entry),
      .rsp_if     (rsp_if)
   );

   // Rounded magnitude stays within the sensor range.
   a_hund_range : assert property (@(posedge clock) disable iff (reset)
      front_valid |-> (front_entry.hund <= tw_pkg::HUND_MAX))
      else $error("hundredths out of range");

   // A minus sign is only ever attached to a nonzero value.
   a_neg_nonzero : assert property (@(posedge clock) disable iff (reset)
      (front_valid && front_entry.neg) |-> (front_entry.hund != '0))
      else $error("negative zero classified");

   // Hold a classified word while the queue is full.
   a_front_hold : assert property (@(posedge clock) disable iff (reset)
      (front_valid && !front_ready) |=> (front_valid && $stable(front_entry)))
      else $error("front entry lost while queue full");

   // Pop only from a queue that holds something.
   a_pop_valid : assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("pop from empty queue");

endmodule

FILE: test/temperature_word_to_ascii_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for temperature_word_to_ascii: sensor words in, ASCII characters out.
// Depends on tw_pkg and the channel interfaces in tw_ifs, plus the block itself.
module temperature_word_to_ascii_tb;

   localparam int CYCLE_LIMIT   = 400000;  // far above the slowest legal run
   localparam int DRAIN_CYCLES  = 16;      // margin after the text drains, to catch strays
   localparam int RANDOM_WORDS  = 150;     // per idling phase
   localparam int DIRECTED_ROWS = 22;

   // One character of the text we expect the block to spell.
   typedef struct packed {
      logic [tw_pkg::CHAR_W-1:0] code;
      logic                      last;
   } text_char_type;

   logic clock = 1'b0;
   logic reset;

   tw_req_if req_if ();
   tw_rsp_if rsp_if ();

   temperature_word_to_ascii u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   text_char_type pending_text[$];
   int            mismatches = 0;
   int            run_cycles = 0;
   int            send_idle_pct = 0;
   int            recv_idle_pct = 0;

   // Directed table. A non-empty text is the exact string expected; an empty one
   // leaves the row to the predictor. Raw words are sign-extended sensor counts.
   int directed_raw [DIRECTED_ROWS] = '{
      0, 1, -1, 2, -2, 8, 16, -16, 2047, -2048, 1599, 1600, -1599, -1600,
      160, 400, 3, -3, 1234, -1234, 1601, -2047
   };
   string directed_text [DIRECTED_ROWS] = '{
      "+00.00",     // zero keeps the plus sign
      "+00.06",
      "-00.06",     // smallest negative keeps its minus sign
      "+00.13",     // exact half, rounds up
      "-00.13",     // exact half, rounds away from zero on the negative side
      "+00.50",
      "+01.00",
      "-01.00",
      "+127.94",    // top of the sensor range
      "-128.00",    // bottom of the sensor range
      "+99.94",     // longest six-character text
      "+100.00",    // first seven-character text
      "-99.94",
      "-100.00",
      "+10.00",
      "+25.00",
      "", "", "", "", "", ""
   };

   // 100 MHz clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
      mismatches++;
   endtask

   function automatic void push_char(input logic [tw_pkg::CHAR_W-1:0] code,
                                     input logic last);
      text_char_type c;
      c.code = code;
      c.last = last;
      pending_text.push_back(c);
   endfunction

   function automatic void queue_typed_text(input string text);
      for (int i = 0; i < text.len(); i++)
         push_char(tw_pkg::CHAR_W'(text[i]), i == text.len() - 1);
   endfunction

   // Spell one word the way the block should: hundredths rounded half away from
   // zero, sign kept, ten-thousands digit only when nonzero.
   function automatic void queue_temperature_text(input logic [tw_pkg::RAW_W-1:0] word);
      int unsigned               mag;
      int unsigned               hund;
      logic [tw_pkg::CHAR_W-1:0] sign_char;
      mag  = word[tw_pkg::RAW_W-1] ? (1 << tw_pkg::RAW_W) - word : word;
      hund = (mag * 625 + 50) / 100;
      sign_char = (word[tw_pkg::RAW_W-1] && hund != 0) ? tw_pkg::CHAR_MINUS
                                                      : tw_pkg::CHAR_PLUS;
      push_char(sign_char, 1'b0);
      if (hund >= 10000)
         push_char(tw_pkg::CHAR_ZERO + tw_pkg::CHAR_W'(hund / 10000), 1'b0);
      push_char(tw_pkg::CHAR_ZERO + tw_pkg::CHAR_W'((hund / 1000) % 10), 1'b0);
      push_char(tw_pkg::CHAR_ZERO + tw_pkg::CHAR_W'((hund / 100) % 10), 1'b0);
      push_char(tw_pkg::CHAR_DOT, 1'b0);
      push_char(tw_pkg::CHAR_ZERO + tw_pkg::CHAR_W'((hund / 10) % 10), 1'b0);
      push_char(tw_pkg::CHAR_ZERO + tw_pkg::CHAR_W'(hund % 10), 1'b1);
   endfunction

   // Bias the random words towards the interesting corners: tiny values around
   // zero, the seven-character region, and exact halves of a hundredth.
   function automatic logic [tw_pkg::RAW_W-1:0] pick_sensor_word();
      int m;
      logic neg;
      neg = 1'($urandom_range(1));
      case ($urandom_range(7))
         0: begin
            m = $urandom_range(40);
         end
         1: begin
            m = $urandom_range(2048, 1590);
            if (!neg && m > 2047) m = 2047;
         end
         2: begin
            m = ($urandom_range(511) << 2) | 2;
         end
         default: begin
            return tw_pkg::RAW_W'($urandom_range((1 << tw_pkg::RAW_W) - 1));
         end
      endcase
      return neg ? tw_pkg::RAW_W'(0 - m) : tw_pkg::RAW_W'(m);
   endfunction

   // Offer one word, holding it until the transfer, then queue its text.
   task automatic send_word(input logic [tw_pkg::RAW_W-1:0] word, input string text);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid    <= 1'b1;
      req_if.raw_temp <= word;
      do @(posedge clock); while (!req_if.ready);
      if (text.len() != 0)
         queue_typed_text(text);
      else
         queue_temperature_text(word);
   endtask

   // Receive side: check each transfer against the oldest pending character,
   // then pick the next ready level.
   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (pending_text.size() == 0) begin
               report_mismatch("character with no text pending", rsp_if.char_code, 0);
            end else begin
               want = pending_text.pop_front();
               if (rsp_if.char_code !== want.code)
                  report_mismatch("char_code", rsp_if.char_code, want.code);
               if (rsp_if.last_char !== want.last)
                  report_mismatch("last_char", rsp_if.last_char, want.last);
            end
         end
         rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      run_cycles <= run_cycles + 1;
      if (run_cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset           <= 1'b1;
      req_if.valid    <= 1'b0;
      req_if.raw_temp <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int phase = 0; phase < 3; phase++) begin
         // Phase 0: sender mostly busy, receiver mostly stalling; phase 1 the
         // other way round; phase 2 runs flat out.
         case (phase)
            0: begin send_idle_pct = 17; recv_idle_pct = 88; end
            1: begin send_idle_pct = 88; recv_idle_pct = 17; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         if (phase == 0)
            for (int row = 0; row < DIRECTED_ROWS; row++)
               send_word(tw_pkg::RAW_W'(directed_raw[row]), directed_text[row]);
         repeat (RANDOM_WORDS)
            send_word(pick_sensor_word(), "");
      end
      req_if.valid <= 1'b0;

      // Drain the outstanding text, then hold a little longer to catch strays.
      while (pending_text.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
